/* hw/rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared types, operation and status codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DeqDepth = 16;
	localparam int ValW     = 32;
	localparam int OccW     = 5;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DUMP_FWD   = 3'd4,
		OP_DUMP_REV   = 3'd5,
		OP_OCCUPANCY  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                     op;
		logic signed [ValW-1:0]  item_value;
	} req_t;

	typedef struct packed {
		logic signed [ValW-1:0]  result_value;
		status_t                 status;
		logic        [OccW-1:0]  occupancy;
		logic                    last_of_run;
	} rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/deq_mem.sv */
// ----------------------------------------------------------------------------
// Double-ended queue entry store
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_mem
	import deq_pkg::*;
#(
	parameter int DEPTH = DeqDepth,
	localparam int IW = $clog2(DEPTH)
) (
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [IW-1:0]          wr_addr,
	input  wire logic signed [ValW-1:0] wr_data,
	input  wire logic                   rd_en,
	input  wire logic [IW-1:0]          rd_addr,
	output logic signed [ValW-1:0]      rd_data
);

	logic signed [ValW-1:0] mem_q [DEPTH];
	logic signed [ValW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of signed 32-bit values kept in a ring of RAM slots.
// ----------------------------------------------------------------------------
// Each request on the req channel carries an operation and a value. Results
// leave on the rsp channel through an output register, one per cycle at most.
// Push, occupancy, any other code, and any pop or dump of an empty queue
// produce one result in the cycle after the request; the next request can
// be taken straight after. A pop reads the entry RAM, whose read data is
// registered; its result passes through that register and then the output
// register, and no request is taken meanwhile. A dump of n entries gives n
// results, one RAM read per entry; requests stall until the last is loaded.
// A push into a full queue is dropped and answered with status full.
// Reset clears the front index, the entry count and the output register; the
// entry RAM is not cleared and is only read at slots that hold entries.
// While the receiver stalls, the result is held and new requests stall once
// the output register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int DEPTH = DeqDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   front_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   off_q;
	logic [IW-1:0]   left_q;
	logic            fwd_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic                   out_free;
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [IW-1:0]          front_dec;
	logic [IW-1:0]          front_inc;
	logic [IW-1:0]          last_off;
	logic [IW-1:0]          next_off;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic signed [ValW-1:0] rd_data;

	function automatic logic [IW-1:0] slot(input logic [IW-1:0] front,
			input logic [IW-1:0] off);
		logic [IW:0] sum;
		sum = {1'b0, front} + {1'b0, off};
		if (sum >= (IW+1)'(DEPTH)) begin
			sum = sum - (IW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	always_comb begin
		out_free  = !rsp_valid_q || !rsp_stall;
		req_stall = !((state_q == ST_IDLE) && out_free);
		accept    = req_valid && !req_stall;
		full      = (count_q == CW'(DEPTH));
		empty     = (count_q == '0);
		front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
		last_off  = IW'(count_q - 1'b1);
		next_off  = fwd_q ? off_q + 1'b1 : off_q - 1'b1;
		wr_en     = 1'b0;
		wr_addr   = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		if (accept) begin
			unique case (req.op)
				OP_PUSH_FRONT: begin
					wr_en   = !full;
					wr_addr = front_dec;
				end
				OP_PUSH_BACK: begin
					wr_en   = !full;
					wr_addr = slot(front_q, IW'(count_q));
				end
				OP_POP_FRONT, OP_DUMP_FWD: begin
					rd_en   = !empty;
					rd_addr = front_q;
				end
				OP_POP_BACK, OP_DUMP_REV: begin
					rd_en   = !empty;
					rd_addr = slot(front_q, last_off);
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_READ) && out_free && (left_q != '0)) begin
			rd_en   = 1'b1;
			rd_addr = slot(front_q, next_off);
		end
	end

	deq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.item_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			off_q       <= '0;
			left_q      <= '0;
			fwd_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.op)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								rsp_valid_q       <= 1'b1;
								rsp_q.last_of_run <= 1'b1;
								if (full) begin
									rsp_q.result_value <= '0;
									rsp_q.status       <= STATUS_FULL;
									rsp_q.occupancy    <= OccW'(count_q);
								end else begin
									if (req.op == OP_PUSH_FRONT) begin
										front_q <= front_dec;
									end
									count_q            <= count_q + 1'b1;
									rsp_q.result_value <= req.item_value;
									rsp_q.status       <= STATUS_OK;
									rsp_q.occupancy    <= OccW'(count_q + 1'b1);
								end
							end
							OP_POP_FRONT, OP_POP_BACK, OP_DUMP_FWD, OP_DUMP_REV: begin
								if (empty) begin
									rsp_valid_q        <= 1'b1;
									rsp_q.result_value <= '0;
									rsp_q.status       <= STATUS_EMPTY;
									rsp_q.occupancy    <= OccW'(count_q);
									rsp_q.last_of_run  <= 1'b1;
								end else begin
									rsp_valid_q <= 1'b0;
									state_q     <= ST_READ;
									if (req.op == OP_POP_FRONT || req.op == OP_POP_BACK) begin
										left_q  <= '0;
										count_q <= count_q - 1'b1;
										if (req.op == OP_POP_FRONT) begin
											front_q <= front_inc;
										end
									end else begin
										left_q <= last_off;
										fwd_q  <= (req.op == OP_DUMP_FWD);
										off_q  <= (req.op == OP_DUMP_FWD) ? '0 : last_off;
									end
								end
							end
							default: begin
								rsp_valid_q        <= 1'b1;
								rsp_q.result_value <= '0;
								rsp_q.status       <= STATUS_OK;
								rsp_q.occupancy    <= OccW'(count_q);
								rsp_q.last_of_run  <= 1'b1;
							end
						endcase
					end else if (out_free) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					if (out_free) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.result_value <= rd_data;
						rsp_q.status       <= STATUS_OK;
						rsp_q.occupancy    <= OccW'(count_q);
						rsp_q.last_of_run  <= (left_q == '0);
						if (left_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							off_q  <= next_off;
							left_q <= left_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* hw/rtl/deq_checker.sv */
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions for the double-ended queue unit, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DeqDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or dropped.");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_FULL |->
			rsp.result_value == '0 && rsp.last_of_run && rsp.occupancy == OccW'(DEPTH))
		else $error("Full response with wrong value, mark or occupancy.");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_EMPTY |->
			rsp.result_value == '0 && rsp.last_of_run && rsp.occupancy == '0)
		else $error("Empty response with wrong value, mark or occupancy.");

	a_stall_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_of_run |-> req_stall)
		else $error("Request accepted while a dump is still running.");

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire

/* sim/deq_observer.sv */
// ----------------------------------------------------------------------------
// Double-ended queue observer
// Watches both channels of the double-ended queue unit, predicts each result
// from its own copy of the ring and compares the results field by field.
// ----------------------------------------------------------------------------
module deq_observer
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding,
	output int   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [ValW-1:0] shadow_slots [DeqDepth];
	int shadow_front;
	int shadow_fill;
	rsp_t results_due [$];

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		results_seen = 0;
		shadow_front = 0;
		shadow_fill  = 0;
	end

	task automatic due(input logic signed [ValW-1:0] v, input status_t st, input logic last);
		rsp_t o;
		o.result_value = v;
		o.status       = st;
		o.occupancy    = OccW'(shadow_fill);
		o.last_of_run  = last;
		results_due.push_back(o);
		outstanding++;
	endtask

	task automatic apply_deq_op(input req_t r);
		int n;
		int off;
		case (r.op)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			if (shadow_fill >= DeqDepth) begin
				due('0, STATUS_FULL, 1'b1);
			end else begin
				if (r.op == OP_PUSH_FRONT) begin
					shadow_front = (shadow_front + DeqDepth - 1) % DeqDepth;
					shadow_slots[shadow_front] = r.item_value;
				end else begin
					shadow_slots[(shadow_front + shadow_fill) % DeqDepth] = r.item_value;
				end
				shadow_fill++;
				due(r.item_value, STATUS_OK, 1'b1);
			end
		end
		OP_POP_FRONT, OP_POP_BACK: begin
			if (shadow_fill == 0) begin
				due('0, STATUS_EMPTY, 1'b1);
			end else if (r.op == OP_POP_FRONT) begin
				off = shadow_front;
				shadow_front = (shadow_front + 1) % DeqDepth;
				shadow_fill--;
				due(shadow_slots[off], STATUS_OK, 1'b1);
			end else begin
				off = (shadow_front + shadow_fill - 1) % DeqDepth;
				shadow_fill--;
				due(shadow_slots[off], STATUS_OK, 1'b1);
			end
		end
		OP_DUMP_FWD, OP_DUMP_REV: begin
			if (shadow_fill == 0) begin
				due('0, STATUS_EMPTY, 1'b1);
			end else begin
				n = shadow_fill;
				for (int i = 0; i < n; i++) begin
					off = (r.op == OP_DUMP_FWD) ? i : (n - 1 - i);
					due(shadow_slots[(shadow_front + off) % DeqDepth], STATUS_OK, i + 1 == n);
				end
			end
		end
		default: begin
			due('0, STATUS_OK, 1'b1);
		end
		endcase
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		results_seen++;
		if (results_due.size() == 0) begin
			fail_count++;
			$display("%0t: result with nothing due: value %h status %0d occupancy %0d last %0b",
				$time, got.result_value, got.status, got.occupancy, got.last_of_run);
		end else begin
			want = results_due.pop_front();
			outstanding--;
			if (got.result_value !== want.result_value) begin
				fail_count++;
				$display("%0t: result_value expected %h, actual %h",
					$time, want.result_value, got.result_value);
			end
			if (got.status !== want.status) begin
				fail_count++;
				$display("%0t: status expected %0d, actual %0d",
					$time, want.status, got.status);
			end
			if (got.occupancy !== want.occupancy) begin
				fail_count++;
				$display("%0t: occupancy expected %0d, actual %0d",
					$time, want.occupancy, got.occupancy);
			end
			if (got.last_of_run !== want.last_of_run) begin
				fail_count++;
				$display("%0t: last_of_run expected %0b, actual %0b",
					$time, want.last_of_run, got.last_of_run);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_front = 0;
			shadow_fill  = 0;
			results_due.delete();
			outstanding  = 0;
		end else begin
			if (req_valid && !req_stall) apply_deq_op(req);
			if (rsp_valid && !rsp_stall) check_result(rsp);
		end
	end

endmodule

/* sim/double_ended_queue_unit_tb.sv */
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives directed and random request sequences with bursty timing and a
// stalling receiver; the observer predicts and checks every result.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import deq_pkg::*;

	localparam logic [2:0] OpSpare = 3'd7;
	localparam int RandomItems = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int results_seen;

	int sent = 0;
	int level = 0;
	int burst_left = 0;
	int fill_runs = 0;

	double_ended_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	deq_observer u_observer (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// The receiver switches between free flow, scattered stalls and long stalls.
	initial begin
		int mode;
		int span;
		int hold;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(32, 200);
			while (span > 0) begin
				@(posedge clk);
				span--;
				if (hold > 0) begin
					hold--;
				end else if (mode == 0) begin
					rsp_stall <= 1'b0;
				end else if (mode == 1) begin
					rsp_stall <= ($urandom_range(0, 99) < 30);
				end else begin
					hold = $urandom_range(0, 8);
					rsp_stall <= ~rsp_stall;
				end
			end
		end
	end

	function automatic logic signed [ValW-1:0] pick_value();
		case ($urandom_range(0, 7))
		0: return 32'sh7fffffff;
		1: return 32'sh80000000;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	task automatic send_req(input logic [2:0] code, input logic signed [ValW-1:0] v);
		req_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		r.op = op_t'(code);
		r.item_value = v;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
		case (code)
		OP_PUSH_FRONT, OP_PUSH_BACK: if (level < DeqDepth) level++;
		OP_POP_FRONT, OP_POP_BACK: if (level > 0) level--;
		default: ;
		endcase
	endtask

	task automatic wait_all_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_push();
		send_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
	endtask

	task automatic random_pop();
		send_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_value());
	endtask

	task automatic random_dump();
		send_req($urandom_range(0, 1) ? OP_DUMP_REV : OP_DUMP_FWD, pick_value());
	endtask

	initial begin
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(OP_POP_FRONT, 32'sh7fffffff);
		send_req(OP_POP_BACK, 32'sh80000000);
		send_req(OP_DUMP_FWD, '1);
		send_req(OP_DUMP_REV, '0);
		send_req(OP_OCCUPANCY, $urandom);
		send_req(OpSpare, $urandom);
		send_req(OP_PUSH_FRONT, 32'sh7fffffff);
		send_req(OP_PUSH_BACK, 32'sh80000000);
		send_req(OP_PUSH_FRONT, '1);
		send_req(OP_PUSH_BACK, '0);
		send_req(OP_DUMP_FWD, $urandom);
		send_req(OP_DUMP_REV, $urandom);
		send_req(OP_OCCUPANCY, $urandom);
		send_req(OP_POP_FRONT, $urandom);
		send_req(OP_POP_BACK, $urandom);
		send_req(OP_POP_FRONT, $urandom);
		send_req(OP_POP_BACK, $urandom);
		send_req(OP_POP_FRONT, $urandom);
		wait_all_results();

		while (sent < RandomItems + 18) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				fill_runs++;
				while (level < DeqDepth) random_push();
				n = $urandom_range(1, 3);
				repeat (n) random_push();
				random_dump();
				n = $urandom_range(0, DeqDepth);
				repeat (n) random_pop();
			end
			2: begin
				while (level > 0) random_pop();
				n = $urandom_range(1, 2);
				repeat (n) random_pop();
				random_dump();
			end
			3: begin
				wait_all_results();
				random_dump();
				send_req($urandom_range(0, 1) ? OP_OCCUPANCY : OpSpare, pick_value());
			end
			default: begin
				n = $urandom_range(5, 15);
				repeat (n) begin
					case ($urandom_range(0, 9))
					0, 1, 2, 3: random_push();
					4, 5, 6: random_pop();
					7: random_dump();
					default: send_req(3'($urandom_range(6, 7)), pick_value());
					endcase
				end
			end
			endcase
		end

		wait_all_results();
		repeat (20) @(posedge clk);

		$display("Covered %0d requests with %0d results checked, %0d runs to a full queue,",
			sent, results_seen, fill_runs);
		$display("including empty-queue answers, dropped pushes and dumps in both orders.");
		if (fail_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/deq_pkg.sv
hw/rtl/deq_mem.sv
hw/rtl/double_ended_queue_unit.sv
hw/rtl/deq_checker.sv
sim/deq_observer.sv
sim/double_ended_queue_unit_tb.sv
